[src/acpu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package acpu_pkg;

    localparam int P_MEM_DEPTH = 256;

    localparam logic [7:0] OP_STA = 8'd16;
    localparam logic [7:0] OP_LDA = 8'd32;
    localparam logic [7:0] OP_ADD = 8'd48;
    localparam logic [7:0] OP_OR  = 8'd64;
    localparam logic [7:0] OP_AND = 8'd80;
    localparam logic [7:0] OP_NOT = 8'd96;
    localparam logic [7:0] OP_JMP = 8'd128;
    localparam logic [7:0] OP_JN  = 8'd144;
    localparam logic [7:0] OP_JZ  = 8'd160;
    localparam logic [7:0] OP_OUT = 8'd172;
    localparam logic [7:0] OP_HLT = 8'd240;

    typedef enum logic [1:0] {
        FN_WRITE,
        FN_READ,
        FN_START,
        FN_EXEC
    } t_func;

    typedef enum logic [0:0] {
        CFG_START_ACC,
        CFG_START_PC
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPC,
        ST_ARG,
        ST_EXE,
        ST_RDW,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] addr;
        logic [7:0] wdata;
    } t_in;

    typedef struct packed {
        logic [7:0] rdata;
        logic       out_valid;
        logic [7:0] out_char;
        logic       halted;
        logic [7:0] acc_now;
        logic [7:0] pc_now;
        logic       neg_flag;
        logic       zero_flag;
    } t_out;

    typedef struct packed {
        logic       en;
        logic       we;
        logic [7:0] addr;
        logic [7:0] wdata;
    } t_mem_req;

endpackage

`default_nettype wire

[src/acpu_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module acpu_mem
    import acpu_pkg::*;
#(
    parameter int MEM_DEPTH = P_MEM_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_mem_req   i_req,
    output logic [7:0]      o_rdata
);

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [7:0]           r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid;
    logic [7:0]           r_rdata;
    logic                 r_hit;
    logic                 w_in_range;
    logic [AW-1:0]        w_idx;
    logic                 w_wr;
    logic                 w_rd;

    // Entries never written since reset read as zero through the valid bits.
    assign w_in_range = ({1'b0, i_req.addr} < 9'(MEM_DEPTH));
    assign w_idx      = i_req.addr[AW-1:0];
    assign w_wr       = i_req.en && i_req.we && w_in_range;
    assign w_rd       = i_req.en && !i_req.we;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_idx] <= i_req.wdata;
        end
        if (w_rd) begin
            r_rdata <= r_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (w_wr) begin
                r_valid[w_idx] <= 1'b1;
            end
            if (w_rd) begin
                r_hit <= w_in_range && r_valid[w_idx];
            end
        end
    end

    assign o_rdata = r_hit ? r_rdata : 8'd0;

endmodule

`default_nettype wire

[src/acpu_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module acpu_ctrl
    import acpu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in        i_in,
    input  wire logic       i_slot_free,
    output logic            o_emit,
    output t_out            o_res,
    output t_mem_req        o_mem_req,
    input  wire logic [7:0] i_mem_rdata,
    input  wire logic       i_cfg_we,
    input  wire logic [0:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_wdata
);

    t_state     r_state;
    t_state     n_state;
    logic [7:0] r_acc;
    logic [7:0] r_pc;
    logic       r_halt;
    logic [7:0] r_op;
    logic [7:0] r_arg;
    logic [7:0] r_rdata;
    logic       r_outv;
    logic [7:0] r_ch;
    logic [7:0] r_start_acc;
    logic [7:0] r_start_pc;
    logic [7:0] n_acc;
    logic [7:0] n_pc;
    logic       n_halt;
    logic       n_outv;
    logic       w_take;
    logic       w_acc;
    logic [7:0] w_pc1;
    logic [7:0] w_pc2;

    assign w_take = (r_state == ST_IDLE) || ((r_state == ST_FIN) && i_slot_free);
    assign w_acc  = i_valid && w_take;
    assign w_pc1  = r_pc + 8'd1;
    assign w_pc2  = r_pc + 8'd2;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE, ST_FIN: begin
                if (r_state == ST_FIN && i_slot_free) begin
                    n_state = ST_IDLE;
                end
                if (w_acc) begin
                    case (i_in.func)
                        FN_WRITE: n_state = ST_FIN;
                        FN_READ:  n_state = ST_RDW;
                        FN_START: n_state = ST_FIN;
                        FN_EXEC:  n_state = r_halt ? ST_FIN : ST_OPC;
                        default:  n_state = ST_FIN;
                    endcase
                end
            end
            ST_OPC:  n_state = ST_ARG;
            ST_ARG:  n_state = ST_EXE;
            ST_EXE:  n_state = ST_FIN;
            ST_RDW:  n_state = ST_FIN;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = w_take;
        o_emit    = (r_state == ST_FIN) && i_slot_free;
        o_mem_req = '0;
        case (r_state)
            ST_IDLE, ST_FIN: begin
                if (w_acc) begin
                    case (i_in.func)
                        FN_WRITE: begin
                            o_mem_req.en    = 1'b1;
                            o_mem_req.we    = 1'b1;
                            o_mem_req.addr  = i_in.addr;
                            o_mem_req.wdata = i_in.wdata;
                        end
                        FN_READ: begin
                            o_mem_req.en   = 1'b1;
                            o_mem_req.addr = i_in.addr;
                        end
                        FN_EXEC: begin
                            o_mem_req.en   = !r_halt;
                            o_mem_req.addr = r_pc;
                        end
                        default: o_mem_req = '0;
                    endcase
                end
            end
            ST_OPC: begin
                o_mem_req.en   = 1'b1;
                o_mem_req.addr = w_pc1;
            end
            ST_ARG: begin
                case (r_op)
                    OP_STA: begin
                        o_mem_req.en    = 1'b1;
                        o_mem_req.we    = 1'b1;
                        o_mem_req.addr  = i_mem_rdata;
                        o_mem_req.wdata = r_acc;
                    end
                    OP_LDA, OP_ADD, OP_OR, OP_AND: begin
                        o_mem_req.en   = 1'b1;
                        o_mem_req.addr = i_mem_rdata;
                    end
                    default: o_mem_req = '0;
                endcase
            end
            default: o_mem_req = '0;
        endcase
    end

    // Instruction effect; in the execute state the memory port holds the operand data.
    always_comb begin
        n_acc  = r_acc;
        n_pc   = w_pc2;
        n_halt = r_halt;
        n_outv = 1'b0;
        case (r_op)
            OP_STA: n_pc = w_pc2;
            OP_LDA: n_acc = i_mem_rdata;
            OP_ADD: n_acc = r_acc + i_mem_rdata;
            OP_OR:  n_acc = r_acc | i_mem_rdata;
            OP_AND: n_acc = r_acc & i_mem_rdata;
            OP_NOT: begin
                n_acc = ~r_acc;
                n_pc  = w_pc1;
            end
            OP_JMP: n_pc = r_arg;
            OP_JN:  n_pc = r_acc[7] ? r_arg : w_pc2;
            OP_JZ:  n_pc = (r_acc == 8'd0) ? r_arg : w_pc2;
            OP_OUT: begin
                n_outv = 1'b1;
                n_pc   = w_pc1;
            end
            OP_HLT: begin
                n_halt = 1'b1;
                n_pc   = w_pc1;
            end
            default: n_pc = w_pc1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= 8'd0;
            r_pc        <= 8'd0;
            r_halt      <= 1'b0;
            r_rdata     <= 8'd0;
            r_outv      <= 1'b0;
            r_ch        <= 8'd0;
            r_start_acc <= 8'd0;
            r_start_pc  <= 8'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_ACC: r_start_acc <= i_cfg_wdata;
                    CFG_START_PC:  r_start_pc  <= i_cfg_wdata;
                    default:       r_start_acc <= r_start_acc;
                endcase
            end
            if (w_acc) begin
                r_rdata <= 8'd0;
                r_outv  <= 1'b0;
                r_ch    <= 8'd0;
                if (i_in.func == FN_START) begin
                    r_acc  <= r_start_acc;
                    r_pc   <= r_start_pc;
                    r_halt <= 1'b0;
                end
            end
            case (r_state)
                ST_EXE: begin
                    r_acc  <= n_acc;
                    r_pc   <= n_pc;
                    r_halt <= n_halt;
                    r_outv <= n_outv;
                    r_ch   <= n_outv ? n_acc : 8'd0;
                end
                ST_RDW:  r_rdata <= i_mem_rdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OPC) begin
            r_op <= i_mem_rdata;
        end
        if (r_state == ST_ARG) begin
            r_arg <= i_mem_rdata;
        end
    end

    always_comb begin
        o_res.rdata     = r_rdata;
        o_res.out_valid = r_outv;
        o_res.out_char  = r_ch;
        o_res.halted    = r_halt;
        o_res.acc_now   = r_acc;
        o_res.pc_now    = r_pc;
        o_res.neg_flag  = r_acc[7];
        o_res.zero_flag = (r_acc == 8'd0);
    end

endmodule

`default_nettype wire

[src/accumulator_cpu_8bit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Beat
// input     in         i_valid / o_ready   t_in  (func, addr, wdata)
// result    out        o_valid / i_ready   t_out (rdata ... zero_flag)
// config    in         i_cfg_we            i_cfg_idx, i_cfg_wdata
//
// An execute beat does opcode fetch, operand fetch and data access over the single memory
// port; the finishing state accepts the next beat once the result slot is free.
// Write, start and halted execute beats go straight to finishing; reads pass read-wait.
// Reset is synchronous; the memory reads as zero at every address after reset.
// A result waits in the output register; the block can accept the next beat but not finish it.

module accumulator_cpu_8bit
    import acpu_pkg::*;
#(
    parameter int MEM_DEPTH = P_MEM_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in        i_in,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out            o_data,
    input  wire logic       i_cfg_we,
    input  wire logic [0:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_wdata
);

    t_mem_req   w_mem_req;
    logic [7:0] w_mem_rdata;
    logic       w_emit;
    t_out       w_res;
    logic       w_slot_free;
    logic       r_ovalid;
    t_out       r_out;

    assign w_slot_free = !r_ovalid || i_ready;

    acpu_mem #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mem_req),
        .o_rdata(w_mem_rdata)
    );

    acpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .i_slot_free(w_slot_free),
        .o_emit     (w_emit),
        .o_res      (w_res),
        .o_mem_req  (w_mem_req),
        .i_mem_rdata(w_mem_rdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

[src/acpu_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module acpu_checker
    import acpu_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire t_out o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.neg_flag == o_data.acc_now[7])
                 && (o_data.zero_flag == (o_data.acc_now == 8'd0)))
        else $error("flags do not follow the accumulator");

    a_out_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.out_valid |-> (o_data.out_char == o_data.acc_now)
                 && !o_data.halted && (o_data.rdata == 8'd0))
        else $error("OUT beat carries inconsistent fields");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_ready |=> !o_valid)
        else $error("result appeared while the block was busy");

endmodule

bind accumulator_cpu_8bit acpu_checker u_acpu_checker (.*);

`default_nettype wire
